@@ rtl/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg
// Shared constants, command codes and transaction types for the software
// timer table.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int IDENT_BITS = 16;

    localparam int IN_ID_W  = 16;
    localparam int OUT_ID_W = 16;
    localparam int DUR_W    = 32;
    localparam int CMD_W    = 2;
    localparam int ID_W     = (IDENT_BITS < IN_ID_W) ? IDENT_BITS : IN_ID_W;
    localparam int IDX_W    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W    = $clog2(NUM_TIMERS + 1);

    localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_KILL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [IN_ID_W-1:0] timer_ident;
        logic [DUR_W-1:0]   duration;
    } item_t;

    typedef struct packed {
        logic                success;
        logic                expired;
        logic [OUT_ID_W-1:0] expired_ident;
        logic                last;
    } result_t;

    typedef struct packed {
        logic load;
        logic down;
        logic up;
        logic finish;
    } ctl_t;

    typedef struct packed {
        logic down_done;
        logic up_done;
    } sts_t;

endpackage

@@ rtl/stt_controller.sv @@
// ----------------------------------------------------------------------------
// stt_controller
// Sequences one transaction: a newest-first expiry scan for a tick, an
// oldest-first compacting walk over the table, and a final update step.
// ----------------------------------------------------------------------------
module stt_controller (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [stt_pkg::CMD_W-1:0] command,
    input  stt_pkg::sts_t             sts,
    output stt_pkg::ctl_t             ctl,
    output logic                      busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DOWN = 2'd1;
    localparam logic [1:0] ST_UP   = 2'd2;
    localparam logic [1:0] ST_END  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    unique case (command) inside
                        stt_pkg::CMD_TICK:                  state_next = ST_DOWN;
                        stt_pkg::CMD_SET, stt_pkg::CMD_KILL: state_next = ST_UP;
                        default:                            state_next = ST_END;
                    endcase
                end
            end
            ST_DOWN:
            begin
                ctl.down = 1'b1;
                if (sts.down_done)
                begin
                    state_next = ST_UP;
                end
            end
            ST_UP:
            begin
                ctl.up = 1'b1;
                if (sts.up_done)
                begin
                    state_next = ST_END;
                end
            end
            ST_END:
            begin
                ctl.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ rtl/stt_datapath.sv @@
// ----------------------------------------------------------------------------
// stt_datapath
// Timer table memory with its read and write pointers, the entry count, the
// expiry bookkeeping and the registered result output.
// ----------------------------------------------------------------------------
module stt_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  stt_pkg::item_t   item,
    input  stt_pkg::ctl_t    ctl,
    output stt_pkg::sts_t    sts,
    output stt_pkg::result_t result,
    output logic             done
);

    logic [stt_pkg::ID_W-1:0]  mem_ident [stt_pkg::NUM_TIMERS];
    logic [stt_pkg::DUR_W-1:0] mem_rem   [stt_pkg::NUM_TIMERS];

    stt_pkg::item_t            req_reg;
    stt_pkg::item_t            req_next;
    logic [stt_pkg::CNT_W-1:0] count_reg;
    logic [stt_pkg::CNT_W-1:0] count_next;
    logic [stt_pkg::CNT_W-1:0] idx_reg;
    logic [stt_pkg::CNT_W-1:0] idx_next;
    logic [stt_pkg::CNT_W-1:0] wr_idx_reg;
    logic [stt_pkg::CNT_W-1:0] wr_idx_next;
    logic                      found_reg;
    logic                      found_next;
    logic                      pend_valid_reg;
    logic                      pend_valid_next;
    logic [stt_pkg::ID_W-1:0]  pend_ident_reg;
    logic [stt_pkg::ID_W-1:0]  pend_ident_next;
    logic                      rd_valid_reg;
    logic                      rd_valid_next;
    logic [stt_pkg::ID_W-1:0]  rd_ident_reg;
    logic [stt_pkg::DUR_W-1:0] rd_rem_reg;
    stt_pkg::result_t          res_reg;
    stt_pkg::result_t          res_next;
    logic                      done_reg;
    logic                      done_next;

    logic [stt_pkg::ID_W-1:0]  req_id;
    logic                      rd_match;
    logic                      rd_expire;
    logic [stt_pkg::CNT_W-1:0] idx_dec;
    logic                      rd_issue_down;
    logic                      rd_issue_up;
    logic                      rd_en;
    logic [stt_pkg::IDX_W-1:0] rd_addr;
    logic                      table_full;
    logic                      keep;
    logic                      wr_en;
    logic [stt_pkg::IDX_W-1:0] wr_addr;
    logic [stt_pkg::ID_W-1:0]  wr_ident;
    logic [stt_pkg::DUR_W-1:0] wr_rem;

    assign req_id        = stt_pkg::ID_W'(req_reg.timer_ident);
    assign rd_match      = (rd_ident_reg == req_id);
    assign rd_expire     = (rd_rem_reg <= stt_pkg::DUR_W'(1));
    assign idx_dec       = idx_reg - stt_pkg::CNT_W'(1);
    assign rd_issue_down = ctl.down && (idx_reg != '0);
    assign rd_issue_up   = ctl.up && (idx_reg != count_reg);
    assign rd_en         = rd_issue_down || rd_issue_up;
    assign rd_addr       = rd_issue_down ? idx_dec[stt_pkg::IDX_W-1:0]
                                         : idx_reg[stt_pkg::IDX_W-1:0];
    assign table_full    = (count_reg == stt_pkg::CNT_W'(stt_pkg::NUM_TIMERS));

    assign sts.down_done = (idx_reg == '0) && !rd_valid_reg;
    assign sts.up_done   = (idx_reg == count_reg) && !rd_valid_reg;

    always_comb
    begin
        req_next        = req_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        wr_idx_next     = wr_idx_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_ident_next = pend_ident_reg;
        rd_valid_next   = rd_en;
        res_next        = res_reg;
        done_next       = 1'b0;
        keep            = 1'b1;
        wr_en           = 1'b0;
        wr_addr         = wr_idx_reg[stt_pkg::IDX_W-1:0];
        wr_ident        = rd_ident_reg;
        wr_rem          = rd_rem_reg;

        if (ctl.load)
        begin
            req_next        = item;
            idx_next        = (item.command == stt_pkg::CMD_TICK) ? count_reg : '0;
            wr_idx_next     = '0;
            found_next      = 1'b0;
            pend_valid_next = 1'b0;
        end

        if (rd_issue_down)
        begin
            idx_next = idx_dec;
        end
        if (rd_issue_up)
        begin
            idx_next = idx_reg + stt_pkg::CNT_W'(1);
        end

        if (ctl.down && rd_valid_reg && rd_expire)
        begin
            if (pend_valid_reg)
            begin
                done_next              = 1'b1;
                res_next               = '0;
                res_next.expired       = 1'b1;
                res_next.expired_ident = stt_pkg::OUT_ID_W'(pend_ident_reg);
            end
            pend_valid_next = 1'b1;
            pend_ident_next = rd_ident_reg;
        end

        if (ctl.up && rd_valid_reg)
        begin
            unique case (req_reg.command)
                stt_pkg::CMD_SET:
                begin
                    if (rd_match && !found_reg)
                    begin
                        wr_rem     = req_reg.duration;
                        found_next = 1'b1;
                    end
                end
                stt_pkg::CMD_KILL:
                begin
                    if (rd_match && !found_reg)
                    begin
                        keep       = 1'b0;
                        found_next = 1'b1;
                    end
                end
                stt_pkg::CMD_TICK:
                begin
                    keep   = !rd_expire;
                    wr_rem = rd_rem_reg - stt_pkg::DUR_W'(1);
                end
                default:
                begin
                    keep = 1'b1;
                end
            endcase
            if (keep)
            begin
                wr_en       = 1'b1;
                wr_idx_next = wr_idx_reg + stt_pkg::CNT_W'(1);
            end
        end

        if (ctl.finish)
        begin
            done_next     = 1'b1;
            res_next      = '0;
            res_next.last = 1'b1;
            unique case (req_reg.command)
                stt_pkg::CMD_SET:
                begin
                    res_next.success = found_reg || !table_full;
                    if (!found_reg && !table_full)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[stt_pkg::IDX_W-1:0];
                        wr_ident   = req_id;
                        wr_rem     = req_reg.duration;
                        count_next = count_reg + stt_pkg::CNT_W'(1);
                    end
                end
                stt_pkg::CMD_KILL:
                begin
                    res_next.success = found_reg && (req_id != '0);
                    count_next       = (req_id == '0) ? '0 : wr_idx_reg;
                end
                stt_pkg::CMD_TICK:
                begin
                    count_next = wr_idx_reg;
                    if (pend_valid_reg)
                    begin
                        res_next.expired       = 1'b1;
                        res_next.expired_ident = stt_pkg::OUT_ID_W'(pend_ident_reg);
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_ident[wr_addr] <= wr_ident;
            mem_rem[wr_addr]   <= wr_rem;
        end
        if (rd_en)
        begin
            rd_ident_reg <= mem_ident[rd_addr];
            rd_rem_reg   <= mem_rem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            idx_reg        <= '0;
            wr_idx_reg     <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            wr_idx_reg     <= wr_idx_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            rd_valid_reg   <= rd_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        pend_ident_reg <= pend_ident_next;
        res_reg        <= res_next;
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

@@ rtl/software_timer_table.sv @@
// ----------------------------------------------------------------------------
// software_timer_table
// Ordered table of one-shot timers with set, kill and tick commands.
//
//   Channel   Handshake           Payload                      Direction
//   command   start / busy        item   (stt_pkg::item_t)     in
//   result    done (one cycle)    result (stt_pkg::result_t)   out
//
// A transaction is taken when start is high and busy is low. A set or kill
// walks the n active entries once, oldest first, through the single read
// port of the table memory; a tick scans the table newest first for
// expiries, then walks it oldest first to compact it.
// Each result is shown on done for one cycle; the receiver cannot stall.
// Reset empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
module software_timer_table (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  stt_pkg::item_t   item,
    output logic             done,
    output stt_pkg::result_t result
);

    stt_pkg::ctl_t ctl;
    stt_pkg::sts_t sts;

    stt_controller u_controller (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (item.command),
        .sts     (sts),
        .ctl     (ctl),
        .busy    (busy)
    );

    stt_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .ctl    (ctl),
        .sts    (sts),
        .result (result),
        .done   (done)
    );

    // An accepted transaction always makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // The final result of a transaction follows the update step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.last) |-> $past(ctl.finish))
        else $error("final result without a preceding update step");

    // Intermediate expiry results appear only while a tick is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last) |-> (busy && result.expired))
        else $error("intermediate result outside a tick");

endmodule

@@ bench/software_timer_table_tb.sv @@
// ----------------------------------------------------------------------------
// software_timer_table_tb
// Self-checking bench for the software timer table. Commands are driven on
// the start/busy handshake with random idle bursts; a ledger of the timer
// table predicts every result, and each result is compared field by field
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module software_timer_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [stt_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    class timer_ledger;
        logic [stt_pkg::ID_W-1:0]  slot_id   [stt_pkg::NUM_TIMERS];
        logic [stt_pkg::DUR_W-1:0] slot_left [stt_pkg::NUM_TIMERS];
        int                        active;
        stt_pkg::result_t          awaited [$];
        int                        errors;

        function new();
            active = 0;
            errors = 0;
        endfunction

        function void drop_slot(int idx);
            for (int j = idx; j + 1 < active; j++)
            begin
                slot_id[j]   = slot_id[j + 1];
                slot_left[j] = slot_left[j + 1];
            end
            active--;
        endfunction

        // Called for each accepted transaction; queues the results it causes.
        function void note_command(stt_pkg::item_t it);
            logic [stt_pkg::ID_W-1:0] id;
            stt_pkg::result_t         reply;
            stt_pkg::result_t         held;
            bit                       have_held;
            int                       hit;
            id        = it.timer_ident[stt_pkg::ID_W-1:0];
            reply     = '0;
            reply.last = 1'b1;
            hit       = -1;
            have_held = 1'b0;
            held      = '0;
            case (it.command)
                stt_pkg::CMD_SET:
                begin
                    for (int i = 0; i < active; i++)
                    begin
                        if (hit < 0 && slot_id[i] == id)
                            hit = i;
                    end
                    if (hit >= 0)
                    begin
                        slot_left[hit] = it.duration;
                        reply.success  = 1'b1;
                    end
                    else if (active < stt_pkg::NUM_TIMERS)
                    begin
                        slot_id[active]   = id;
                        slot_left[active] = it.duration;
                        active++;
                        reply.success = 1'b1;
                    end
                    awaited.push_back(reply);
                end
                stt_pkg::CMD_KILL:
                begin
                    if (id == '0)
                        active = 0;
                    else
                    begin
                        for (int i = 0; i < active; i++)
                        begin
                            if (hit < 0 && slot_id[i] == id)
                                hit = i;
                        end
                        if (hit >= 0)
                        begin
                            drop_slot(hit);
                            reply.success = 1'b1;
                        end
                    end
                    awaited.push_back(reply);
                end
                stt_pkg::CMD_TICK:
                begin
                    for (int i = active - 1; i >= 0; i--)
                    begin
                        if (slot_left[i] <= 1)
                        begin
                            if (have_held)
                                awaited.push_back(held);
                            held         = '0;
                            held.expired = 1'b1;
                            held.expired_ident[stt_pkg::ID_W-1:0] = slot_id[i];
                            have_held    = 1'b1;
                            drop_slot(i);
                        end
                        else
                            slot_left[i] = slot_left[i] - 1;
                    end
                    if (have_held)
                    begin
                        held.last = 1'b1;
                        awaited.push_back(held);
                    end
                    else
                        awaited.push_back(reply);
                end
                default:
                begin
                    awaited.push_back(reply);
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(stt_pkg::result_t got);
            stt_pkg::result_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: result %h with no transaction outstanding, expected none",
                         $time, got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("success", 32'(want.success), 32'(got.success));
            compare_field("expired", 32'(want.expired), 32'(got.expired));
            compare_field("expired_ident", 32'(want.expired_ident), 32'(got.expired_ident));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    stt_pkg::item_t   item;
    logic             done;
    stt_pkg::result_t result;

    timer_ledger ledger;

    software_timer_table DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic stt_pkg::item_t random_command();
        stt_pkg::item_t it;
        int             pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            it.command = stt_pkg::CMD_SET;
        else if (pick < 60)
            it.command = stt_pkg::CMD_KILL;
        else if (pick < 95)
            it.command = stt_pkg::CMD_TICK;
        else
            it.command = CMD_SPARE;
        if ($urandom_range(0, 9) == 0)
            it.timer_ident = 16'($urandom);
        else
            it.timer_ident = 16'($urandom_range(0, 23));
        if ($urandom_range(0, 9) == 0)
            it.duration = $urandom;
        else
            it.duration = 32'($urandom_range(0, 4));
        return it;
    endfunction

    task automatic send_command(stt_pkg::item_t it);
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ledger.note_command(it);
    endtask

    task automatic send_fields(logic [stt_pkg::CMD_W-1:0]   cmd,
                               logic [stt_pkg::IN_ID_W-1:0] id,
                               logic [stt_pkg::DUR_W-1:0]   dur);
        stt_pkg::item_t it;
        it.command     = cmd;
        it.timer_ident = id;
        it.duration    = dur;
        send_command(it);
    endtask

    task automatic pause_sender(int cycles);
        @(negedge clk);
        start <= 1'b0;
        item  <= random_command();
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
            ledger.check_result(result);
    end

    initial
    begin
        ledger = new();
        rst_n  = 1'b0;
        start  = 1'b0;
        item   = '0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_fields(stt_pkg::CMD_TICK, 16'h0000, 32'h0000_0000);
        send_fields(CMD_SPARE, 16'hFFFF, 32'hFFFF_FFFF);
        send_fields(stt_pkg::CMD_KILL, 16'h0000, 32'h0000_0000);
        send_fields(stt_pkg::CMD_SET, 16'h0000, 32'h0000_0000);
        send_fields(stt_pkg::CMD_SET, 16'hFFFF, 32'hFFFF_FFFF);
        send_fields(stt_pkg::CMD_TICK, 16'h0000, 32'h0000_0000);
        send_fields(stt_pkg::CMD_KILL, 16'hFFFF, 32'h0000_0000);
        for (int k = 1; k <= stt_pkg::NUM_TIMERS; k++)
            send_fields(stt_pkg::CMD_SET, 16'(k), 32'h0000_0001);
        send_fields(stt_pkg::CMD_SET, 16'd100, 32'h0000_0002);
        send_fields(stt_pkg::CMD_SET, 16'd3, 32'h0000_0000);
        send_fields(stt_pkg::CMD_TICK, 16'h0000, 32'h0000_0000);
        send_fields(stt_pkg::CMD_SET, 16'd7, 32'h0000_0003);
        send_fields(stt_pkg::CMD_KILL, 16'h0000, 32'h0000_0000);

        for (int n = 0; n < 92; n++)
        begin
            if (n < 75 && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 15));
            send_command(random_command());
        end
        @(negedge clk);
        start <= 1'b0;

        while (ledger.awaited.size() != 0)
            @(posedge clk);
        repeat (60)
            @(posedge clk);
        if (ledger.errors == 0)
            $display("software_timer_table_tb: clean");
        else
            $display("software_timer_table_tb: errors");
        $finish;
    end

    initial
    begin
        #500000;
        $display("software_timer_table_tb: errors");
        $finish;
    end

endmodule

@@ software_timer_table.f @@
rtl/stt_pkg.sv
rtl/stt_controller.sv
rtl/stt_datapath.sv
rtl/software_timer_table.sv
bench/software_timer_table_tb.sv
